/* rtl/fdws_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fractional delay window statistics block.
// No dependencies.
package fdws_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int WHOLE_W  = 5;
    localparam int SUM_W    = 21;
    localparam int QUOT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WHOLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAC  = 2'd1;

    localparam logic [WHOLE_W-1:0] WHOLE_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

/* rtl/fdws_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on fdws_pkg.
interface fdws_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fdws_pkg::SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fdws_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fdws_pkg::SAMPLE_W-1:0] delayed_value;
    logic signed [fdws_pkg::SAMPLE_W-1:0] window_min;
    logic signed [fdws_pkg::SAMPLE_W-1:0] window_max;
    logic signed [fdws_pkg::SUM_W-1:0]    window_sum;
    logic signed [fdws_pkg::SAMPLE_W-1:0] window_mean;
    modport source (output valid, output delayed_value, output window_min,
                    output window_max, output window_sum, output window_mean,
                    input ready);
    modport sink   (input valid, input delayed_value, input window_min,
                    input window_max, input window_sum, input window_mean,
                    output ready);
endinterface

interface fdws_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fdws_pkg::CFG_IDX_W-1:0]      index;
    logic [fdws_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/fdws_div.sv */
`timescale 1ns / 1ps
// Floored division by the constant DEPTH+1 through a reciprocal multiply.
// Depends on fdws_pkg.
module fdws_div #(
    parameter int DEPTH = 16,
    localparam int SW = fdws_pkg::SAMPLE_W + $clog2(DEPTH + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [SW-1:0]                 i_num,
    output logic                                 o_done,
    output logic signed [fdws_pkg::QUOT_W-1:0]   o_quot
);
    import fdws_pkg::*;

    localparam int NW = SW + 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int RW = NW + 1;
    localparam int MW = NW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << (NW + LW)) + 64'(DEPTH)) / 64'(DEPTH + 1));

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [NW-1:0]     r_num;
    logic [MW-1:0]     r_prod;

    logic signed [NW-1:0] num_x;
    logic [NW-1:0]     mag;
    logic [QUOT_W:0]   quo;
    logic [QUOT_W:0]   qneg;

    // floor of a negative quotient: negate the quotient of |num| + DEPTH
    assign num_x = NW'(i_num);
    assign mag   = num_x[NW-1] ? (NW'(DEPTH) - num_x) : num_x;
    assign quo   = r_prod[NW + LW +: QUOT_W + 1];
    assign qneg  = -quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= num_x[NW-1];
            r_num <= mag;
        end
        if (r_busy) r_prod <= r_num * RECIP;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? qneg[QUOT_W-1:0] : quo[QUOT_W-1:0];

endmodule

/* rtl/fractional_delay_window_stats.sv */
`timescale 1ns / 1ps
// Fractional delay line with window statistics: min, max, sum and floored mean.
// Depends on fdws_pkg, fdws_if and fdws_div.
//
// For each accepted sample, the walk reads the delay-line memory through its single
// registered read port while one compare/add unit folds each tap into min, max and
// sum; the ST_MUL state then forms the interpolation product while the divider takes
// the sum, and a reciprocal multiply in the divider forms the mean. Input ready is high
// only while the sequencer idles, so a new sample is not taken until the sequencer is
// done with the last one; a finished result sits in the output register, so the next
// sample is taken while it waits. The delay line is a circular memory with a fill
// count, so reset needs no clearing pass.
module fractional_delay_window_stats #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdws_in_if.sink     i_in,
    fdws_out_if.source  o_out,
    fdws_cfg_if.sink    i_cfg
);
    import fdws_pkg::*;

    localparam int KW  = $clog2(DEPTH + 2);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW  = SAMPLE_W + $clog2(DEPTH + 1);
    localparam int SXW = (SW > SUM_W) ? SW : SUM_W;
    localparam int PW  = 2 * (SAMPLE_W + 1);

    t_state r_state, n_state;

    logic [WHOLE_W-1:0]         r_whole;
    logic [FRAC_W-1:0]          r_frac;
    logic [KW-1:0]              r_we;
    logic [FRAC_W-1:0]          r_fe;
    logic signed [SAMPLE_W-1:0] r_cur, r_a, r_b, r_mn, r_mx;
    logic signed [SW-1:0]       r_sum;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_q;
    logic [AW-1:0]              r_wp, r_raddr;
    logic [KW-1:0]              r_idx, r_fill, r_rd_k;
    logic                       r_rd_vld;
    logic signed [PW-1:0]       r_prod;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_o_dv, r_o_mn, r_o_mx, r_o_mean;
    logic signed [SUM_W-1:0]    r_o_sum;

    logic                       accept, issue, walk_end, out_free, load_out;
    logic                       div_start, div_done;
    logic signed [QUOT_W-1:0]   div_quot;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   frac_s;
    logic signed [PW-1:0]       interp;
    logic signed [SXW-1:0]      sum_x;
    logic [AW-1:0]              wp_prev;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign issue     = (r_state == ST_WALK) && (r_idx <= KW'(DEPTH));
    assign walk_end  = r_rd_vld && (r_rd_k == KW'(DEPTH));
    assign out_free  = !r_out_valid || o_out.ready;
    assign div_start = (r_state == ST_MUL);
    assign tap       = (r_rd_k <= r_fill) ? r_q : '0;
    assign diff      = (SAMPLE_W + 1)'(r_b) - (SAMPLE_W + 1)'(r_a);
    assign frac_s    = signed'({1'b0, r_fe});
    assign interp    = (PW'(r_a) <<< FRAC_W) + r_prod + PW'(32768);
    assign sum_x     = SXW'(r_sum);
    assign wp_prev   = (r_wp == '0) ? AW'(DEPTH - 1) : r_wp - AW'(1);

    fdws_div #(.DEPTH(DEPTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state  = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_whole     <= WHOLE_RESET;
            r_frac      <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_DELAY_WHOLE: r_whole <= i_cfg.data[WHOLE_W-1:0];
                    CFG_DELAY_FRAC:  r_frac  <= i_cfg.data[FRAC_W-1:0];
                    default: ;
                endcase
            end
            if (walk_end) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != KW'(DEPTH)) r_fill <= r_fill + KW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // delay-line memory: one registered read, one write per sample
    always_ff @(posedge i_clk) begin
        if (issue) r_q <= mem[r_raddr];
        if (walk_end) mem[r_wp] <= r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur   <= i_in.sample;
            r_a     <= i_in.sample;
            r_b     <= i_in.sample;
            r_mn    <= i_in.sample;
            r_mx    <= i_in.sample;
            r_sum   <= SW'(i_in.sample);
            r_idx   <= KW'(1);
            r_raddr <= wp_prev;
            if (32'(r_whole) >= DEPTH) begin
                r_we <= KW'(DEPTH);
                r_fe <= '0;
            end else begin
                r_we <= KW'(r_whole);
                r_fe <= r_frac;
            end
        end else begin
            if (issue) begin
                r_idx   <= r_idx + KW'(1);
                r_rd_k  <= r_idx;
                r_raddr <= (r_raddr == '0) ? AW'(DEPTH - 1) : r_raddr - AW'(1);
            end
            if (r_rd_vld) begin
                if (tap < r_mn) r_mn <= tap;
                if (tap > r_mx) r_mx <= tap;
                r_sum <= r_sum + SW'(tap);
                if (r_rd_k == r_we) r_a <= tap;
                if (r_rd_k == r_we + KW'(1)) r_b <= tap;
            end
        end
        if (r_state == ST_MUL) r_prod <= PW'(diff * frac_s);
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_dv   <= interp[FRAC_W +: SAMPLE_W];
            r_o_mn   <= r_mn;
            r_o_mx   <= r_mx;
            r_o_sum  <= sum_x[SUM_W-1:0];
            r_o_mean <= div_quot;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.delayed_value = r_o_dv;
    assign o_out.window_min    = r_o_mn;
    assign o_out.window_max    = r_o_mx;
    assign o_out.window_sum    = r_o_sum;
    assign o_out.window_mean   = r_o_mean;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= KW'(DEPTH))
        else $error("fill count above depth");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("second sample taken while one is in flight");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

    a_read_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_rd_k >= KW'(1)) && (r_rd_k <= KW'(DEPTH)))
        else $error("tap index out of range");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_o_mn <= r_o_mx) && (r_o_mean >= r_o_mn) && (r_o_mean <= r_o_mx))
        else $error("window statistics inconsistent");
`endif

endmodule
